### hdl/assert_macros.svh
// assertion macros shared by the rtl of the rolling hash pattern counter
// no dependencies; taken in by every module that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define RHPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define RHPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define RHPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RHPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/rhpc_pkg.sv
// types and constants of the rolling hash pattern counter
// no dependencies; imported by the interfaces and every module except rhpc_ram
`timescale 1ns / 1ps

package rhpc_pkg;

	localparam int LEN_W    = 9;
	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 32;
	localparam int HASH_W   = 30;
	localparam int MUL_W    = 8;
	localparam int ACC_W    = HASH_W + MUL_W;
	localparam int FOLD_K_W = 27;
	localparam int FOLD_W   = MUL_W + FOLD_K_W;

	// modulus, base and 2^30 mod the modulus
	localparam logic [HASH_W-1:0]   HASH_MOD  = 30'd1000000007;
	localparam logic [MUL_W-1:0]    HASH_BASE = 8'd31;
	localparam logic [FOLD_K_W-1:0] HASH_FOLD = 27'd73741817;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_TEXT    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	// request to the shared multiply-reduce unit: (x * m + c) mod HASH_MOD
	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] x;
		logic [MUL_W-1:0]  m;
		logic [HASH_W-1:0] c;
	} mm_req_t;

	typedef struct packed {
		logic              done;
		logic [HASH_W-1:0] value;
	} mm_rsp_t;

endpackage

### hdl/rhpc_if.sv
// valid/ready channel interfaces: command word in, result word out, length write
// depends on rhpc_pkg
`timescale 1ns / 1ps

interface rhpc_in_if import rhpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] byte_value;

	modport source (output valid, output command, output byte_value, input ready);
	modport sink   (input valid, input command, input byte_value, output ready);
endinterface

interface rhpc_out_if import rhpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               match_found;
	logic [COUNT_W-1:0] match_count;
	logic               pattern_ready;

	modport source (output valid, output match_found, output match_count,
		output pattern_ready, input ready);
	modport sink   (input valid, input match_found, input match_count,
		input pattern_ready, output ready);
endinterface

interface rhpc_cfg_if import rhpc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] pattern_length;

	modport source (output valid, output pattern_length, input ready);
	modport sink   (input valid, input pattern_length, output ready);
endinterface

### hdl/rhpc_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rhpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/rhpc_modmul.sv
// shared multiply-reduce unit: (x * m + c) mod 1000000007, folded iteratively until it fits
// depends on rhpc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rhpc_modmul import rhpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);
	logic              busy_q;
	logic              done_q;
	logic [ACC_W-1:0]  acc_q;
	logic [HASH_W-1:0] value_q;

	logic [ACC_W-1:0]  prod;
	logic [ACC_W-1:0]  start_acc;
	logic [FOLD_W-1:0] fold_prod;
	logic [ACC_W-1:0]  fold_acc;
	logic [HASH_W-1:0] low;
	logic [HASH_W-1:0] reduced;
	logic              fits;

	assign prod      = req.x * req.m;
	assign start_acc = prod + ACC_W'(req.c);

	// fold the bits above 2^30 back in as hi * (2^30 mod p)
	assign fold_prod = acc_q[ACC_W-1:HASH_W] * HASH_FOLD;
	assign fold_acc  = ACC_W'(fold_prod) + ACC_W'(acc_q[HASH_W-1:0]);
	assign fits      = (acc_q[ACC_W-1:HASH_W] == '0);
	assign low       = acc_q[HASH_W-1:0];
	assign reduced   = (low >= HASH_MOD) ? low - HASH_MOD : low;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && fits) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= start_acc;
		end else if (busy_q && !fits) begin
			acc_q <= fold_acc;
		end
		if (busy_q && fits && !req.start) begin
			value_q <= reduced;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = value_q;

	`RHPC_ASSERT_IMPL(a_no_start_busy, clk, arst_n, req.start, !busy_q, "start while unit busy")
	`RHPC_ASSERT_IMPL(a_done_reduced, clk, arst_n, done_q, value_q < HASH_MOD, "result not reduced")
	`RHPC_ASSERT_IMPL(a_done_idle, clk, arst_n, done_q, !busy_q, "done while still busy")

endmodule

### hdl/rolling_hash_pattern_counter_core.sv
// rabin-karp pattern counter core, one word at a time; ready only when idle
// a pattern or text byte takes one or two passes of the shared multiply-reduce unit,
// each folding the product modulo 2^30 until it fits; other words need no pass
// async reset clears hashes, counters and length (to 1); the window ram is not cleared
// depends on rhpc_pkg, rhpc_if, rhpc_ram, rhpc_modmul and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rolling_hash_pattern_counter_core import rhpc_pkg::*; #(
	parameter int MAX_PATTERN = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	rhpc_cfg_if.sink   cfg,
	rhpc_in_if.sink    item,
	rhpc_out_if.source result
);
	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOADH = 7'b0000010,
		S_LOADP = 7'b0000100,
		S_RD    = 7'b0001000,
		S_SUB   = 7'b0010000,
		S_SHIFT = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [HASH_W-1:0]  ph;
		logic [HASH_W-1:0]  wh;
		logic [HASH_W-1:0]  neg;
		logic [CNT_W-1:0]   loaded;
		logic [CNT_W-1:0]   text;
		logic [PTR_W-1:0]   ptr;
		logic [COUNT_W-1:0] match_cnt;
	} hs_t;

	// neg holds p - base^(L-1), so removing the oldest byte is a multiply-add
	localparam hs_t HS_CLEAR = '{
		ph: '0, wh: '0, neg: HASH_MOD - 30'd1,
		loaded: '0, text: '0, ptr: '0, match_cnt: '0
	};

	state_t             state_q;
	logic [LEN_W-1:0]   len_q;
	hs_t                st_q;
	logic [BYTE_W-1:0]  byte_q;
	logic               found_q;
	logic               res_valid_q;
	logic               res_found_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               res_ready_q;

	logic [CNT_W-1:0]   eff_len;
	cmd_t               cmd;
	logic               item_acc;
	logic               cfg_acc;
	logic               loaded_full;
	logic               text_full;
	logic [PTR_W-1:0]   ptr_cur;
	logic [CNT_W-1:0]   ptr_inc;
	logic [PTR_W-1:0]   ptr_nxt;
	logic [CNT_W-1:0]   text_nxt;
	logic               hit;
	logic               out_free;
	logic               counts_ok;
	logic               ram_re;
	logic               ram_we;
	logic [BYTE_W-1:0]  ram_rdata;
	mm_req_t            req;
	mm_rsp_t            rsp;

	always_comb begin
		if (len_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (32'(len_q) > MAX_PATTERN) begin
			eff_len = CNT_W'(MAX_PATTERN);
		end else begin
			eff_len = CNT_W'(len_q);
		end
	end

	assign cmd         = cmd_t'(item.command);
	assign item.ready  = (state_q == S_IDLE) && !cfg.valid;
	assign cfg.ready   = (state_q == S_IDLE);
	assign item_acc    = item.valid && item.ready;
	assign cfg_acc     = cfg.valid && cfg.ready;
	assign loaded_full = (st_q.loaded >= eff_len);
	assign text_full   = (st_q.text >= eff_len);
	assign ptr_cur     = (CNT_W'(st_q.ptr) >= eff_len) ? '0 : st_q.ptr;
	assign ptr_inc     = CNT_W'(ptr_cur) + CNT_W'(1);
	assign ptr_nxt     = (ptr_inc >= eff_len) ? '0 : PTR_W'(ptr_inc);
	assign text_nxt    = text_full ? st_q.text : st_q.text + CNT_W'(1);
	assign hit         = (text_nxt >= eff_len) && (rsp.value == st_q.ph);
	assign out_free    = !res_valid_q || result.ready;
	assign counts_ok   = (st_q.loaded <= eff_len) && (st_q.text <= eff_len);

	assign ram_re = (state_q == S_IDLE) && item_acc && (cmd == CMD_TEXT)
		&& loaded_full && text_full;
	assign ram_we = (state_q == S_SHIFT) && rsp.done;

	always_comb begin
		req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_acc && cmd == CMD_LOAD && !loaded_full) begin
					req.start = 1'b1;
					req.x     = st_q.ph;
					req.m     = HASH_BASE;
					req.c     = HASH_W'(item.byte_value);
				end else if (item_acc && cmd == CMD_TEXT && loaded_full && !text_full) begin
					req.start = 1'b1;
					req.x     = st_q.wh;
					req.m     = HASH_BASE;
					req.c     = HASH_W'(item.byte_value);
				end
			end
			S_LOADH: begin
				if (rsp.done && st_q.loaded != '0) begin
					req.start = 1'b1;
					req.x     = st_q.neg;
					req.m     = HASH_BASE;
				end
			end
			S_RD: begin
				req.start = 1'b1;
				req.x     = st_q.neg;
				req.m     = ram_rdata;
				req.c     = st_q.wh;
			end
			S_SUB: begin
				if (rsp.done) begin
					req.start = 1'b1;
					req.x     = rsp.value;
					req.m     = HASH_BASE;
					req.c     = HASH_W'(byte_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= LEN_W'(1);
			st_q        <= HS_CLEAR;
			byte_q      <= '0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_acc) begin
				len_q <= cfg.pattern_length;
				st_q  <= HS_CLEAR;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						byte_q  <= item.byte_value;
						found_q <= 1'b0;
						state_q <= S_DONE;
						if (cmd == CMD_RESTART) begin
							st_q <= HS_CLEAR;
						end else if (cmd == CMD_LOAD && !loaded_full) begin
							state_q <= S_LOADH;
						end else if (cmd == CMD_TEXT && loaded_full) begin
							state_q <= text_full ? S_RD : S_SHIFT;
						end
					end
				end
				S_LOADH: begin
					if (rsp.done) begin
						st_q.ph <= rsp.value;
						if (st_q.loaded != '0) begin
							state_q <= S_LOADP;
						end else begin
							st_q.loaded <= st_q.loaded + CNT_W'(1);
							state_q     <= S_DONE;
						end
					end
				end
				S_LOADP: begin
					if (rsp.done) begin
						st_q.neg    <= rsp.value;
						st_q.loaded <= st_q.loaded + CNT_W'(1);
						state_q     <= S_DONE;
					end
				end
				S_RD: begin
					state_q <= S_SUB;
				end
				S_SUB: begin
					if (rsp.done) begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (rsp.done) begin
						st_q.wh   <= rsp.value;
						st_q.ptr  <= ptr_nxt;
						st_q.text <= text_nxt;
						if (hit) begin
							found_q <= 1'b1;
							if (st_q.match_cnt != '1) begin
								st_q.match_cnt <= st_q.match_cnt + COUNT_W'(1);
							end
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			res_found_q <= found_q;
			res_count_q <= st_q.match_cnt;
			res_ready_q <= loaded_full;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.match_found   = res_found_q;
	assign result.match_count   = res_count_q;
	assign result.pattern_ready = res_ready_q;

	rhpc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_PATTERN)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_cur),
		.wdata (byte_q),
		.re    (ram_re),
		.raddr (ptr_cur),
		.rdata (ram_rdata)
	);

	rhpc_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	`RHPC_ASSERT(a_count_bounds, clk, arst_n, counts_ok, "fill count above window length")
	`RHPC_ASSERT_IMPL(a_text_after_pattern, clk, arst_n, st_q.text != '0, loaded_full, "early text")
	`RHPC_ASSERT_IMPL(a_match_ready, clk, arst_n, res_valid_q && res_found_q, res_ready_q, "early match")

endmodule

### bench/tb.sv
// self-checking bench for rolling_hash_pattern_counter_core: random and directed words,
// each result word checked against a rolling hash predictor kept in the bench
// depends on rhpc_pkg, rhpc_if and the core rtl
`timescale 1ns / 1ps

module tb;
	import rhpc_pkg::*;

	localparam int MAX_PATTERN  = 256;
	localparam int IDLE_LIMIT   = 2000;
	localparam int WORD_TARGET  = 800;
	localparam longint MOD_P    = 64'd1000000007;
	localparam longint BASE_P   = 64'd31;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] val;
	} stream_word_t;

	typedef struct {
		logic               found;
		logic [COUNT_W-1:0] count;
		logic               ready;
	} match_report_t;

	logic clk;
	logic arst_n;

	rhpc_in_if  item_ch ();
	rhpc_out_if result_ch ();
	rhpc_cfg_if cfg_ch ();

	rolling_hash_pattern_counter_core #(.MAX_PATTERN(MAX_PATTERN)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	// predictor state
	logic [LEN_W-1:0]   len_reg;
	logic [HASH_W-1:0]  pat_hash;
	logic [HASH_W-1:0]  win_hash;
	logic [HASH_W-1:0]  top_pow;
	int                 pat_loaded;
	int                 text_seen;
	int                 ring_ptr;
	logic [BYTE_W-1:0]  ring_bytes [MAX_PATTERN];
	logic [COUNT_W-1:0] match_total;

	stream_word_t  stream_words [$];
	match_report_t predicted_matches [$];
	logic [BYTE_W-1:0] pattern_bytes [$];

	int  words_pushed;
	int  results_seen;
	int  cfg_seen;
	int  mismatches;
	int  windows_matched;
	int  idle_cycles;
	int  phase_useful;
	bit  item_taken;
	bit  no_gaps;
	bit  byte_mode;
	logic [BYTE_W-1:0] alpha_a;
	logic [BYTE_W-1:0] alpha_b;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int active_len();
		if (len_reg == 0)
			return 1;
		if (len_reg > MAX_PATTERN)
			return MAX_PATTERN;
		return len_reg;
	endfunction

	function automatic void clear_matcher();
		pat_hash    = '0;
		win_hash    = '0;
		top_pow     = HASH_W'(1);
		pat_loaded  = 0;
		text_seen   = 0;
		ring_ptr    = 0;
		match_total = '0;
		foreach (ring_bytes[i])
			ring_bytes[i] = '0;
	endfunction

	function automatic void set_length(input logic [LEN_W-1:0] v);
		len_reg = v;
		clear_matcher();
	endfunction

	function automatic match_report_t rk_advance(input logic [CMD_W-1:0] cmd,
		input logic [BYTE_W-1:0] b);
		match_report_t r;
		int len;
		int ptr;
		longint h;
		longint sub;
		len = active_len();
		r.found = 1'b0;
		case (cmd)
			CMD_RESTART: begin
				clear_matcher();
			end
			CMD_LOAD: begin
				if (pat_loaded < len) begin
					h = (longint'(pat_hash) * BASE_P + longint'(b)) % MOD_P;
					pat_hash = h[HASH_W-1:0];
					if (pat_loaded >= 1) begin
						h = (longint'(top_pow) * BASE_P) % MOD_P;
						top_pow = h[HASH_W-1:0];
					end
					pat_loaded++;
				end
			end
			CMD_TEXT: begin
				if (pat_loaded >= len) begin
					ptr = ring_ptr;
					if (ptr >= len)
						ptr = 0;
					h = longint'(win_hash);
					if (text_seen >= len) begin
						sub = (longint'(ring_bytes[ptr]) * longint'(top_pow)) % MOD_P;
						h = (h + MOD_P - sub) % MOD_P;
					end
					h = (h * BASE_P + longint'(b)) % MOD_P;
					win_hash = h[HASH_W-1:0];
					ring_bytes[ptr] = b;
					ptr++;
					ring_ptr = (ptr >= len) ? 0 : ptr;
					if (text_seen < len)
						text_seen++;
					if (text_seen >= len && win_hash == pat_hash) begin
						r.found = 1'b1;
						if (match_total != '1)
							match_total++;
					end
				end
			end
			default: begin
			end
		endcase
		r.count = match_total;
		r.ready = (pat_loaded >= len);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < 50)
			$display("mismatch at result %0d: %s got %0d expected %0d",
				results_seen, what, got, want);
		mismatches++;
	endtask

	// driver: words change on the falling edge
	always @(negedge clk) begin : drive_blk
		stream_word_t w;
		bit nv;
		if (arst_n) begin
			nv = item_ch.valid && !item_taken;
			if (!nv && stream_words.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 7)) begin
				w = stream_words.pop_front();
				item_ch.command <= w.cmd;
				item_ch.byte_value <= w.val;
				nv = 1'b1;
			end
			item_ch.valid <= nv;
			item_taken = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			result_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 7);
	end

	// monitor, predictor hook and watchdog
	always @(posedge clk) begin : watch_blk
		match_report_t want;
		match_report_t pred;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (result_ch.valid && result_ch.ready) begin
				moved = 1'b1;
				if (predicted_matches.size() == 0) begin
					report_mismatch("result word with nothing pending", 1, 0);
				end else begin
					want = predicted_matches.pop_front();
					if (result_ch.match_found !== want.found)
						report_mismatch("match_found", result_ch.match_found, want.found);
					if (result_ch.match_count !== want.count)
						report_mismatch("match_count", result_ch.match_count, want.count);
					if (result_ch.pattern_ready !== want.ready)
						report_mismatch("pattern_ready", result_ch.pattern_ready, want.ready);
				end
				if (result_ch.match_found === 1'b1)
					windows_matched++;
				results_seen++;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				moved = 1'b1;
				set_length(cfg_ch.pattern_length);
				cfg_seen++;
			end
			if (item_ch.valid && item_ch.ready) begin
				moved = 1'b1;
				pred = rk_advance(item_ch.command, item_ch.byte_value);
				predicted_matches.insert(predicted_matches.size(), pred);
				item_taken = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic push_word(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b,
		input bit useful);
		stream_word_t w;
		w.cmd = c;
		w.val = b;
		stream_words.insert(stream_words.size(), w);
		words_pushed++;
		if (useful)
			phase_useful++;
	endtask

	task automatic wait_idle();
		while (results_seen != words_pushed)
			@(negedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] v);
		int seen0;
		wait_idle();
		@(negedge clk);
		seen0 = cfg_seen;
		cfg_ch.pattern_length <= v;
		cfg_ch.valid <= 1'b1;
		do
			@(negedge clk);
		while (cfg_seen == seen0);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] pick_byte();
		if (byte_mode)
			return $urandom_range(0, 1) ? alpha_a : alpha_b;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic load_pattern(input int eff);
		logic [BYTE_W-1:0] b;
		pattern_bytes.delete();
		// text ahead of the pattern is dropped
		if ($urandom_range(0, 5) == 0)
			push_word(CMD_TEXT, BYTE_W'($urandom), 1'b0);
		repeat (eff) begin
			b = pick_byte();
			pattern_bytes.insert(pattern_bytes.size(), b);
			push_word(CMD_LOAD, b, 1'b1);
		end
	endtask

	task automatic run_phase(input logic [LEN_W-1:0] len_cfg, input int budget);
		int eff;
		int pick;
		int idx;
		logic [BYTE_W-1:0] flip;
		write_length(len_cfg);
		eff = (len_cfg == 0) ? 1 : ((len_cfg > MAX_PATTERN) ? MAX_PATTERN : len_cfg);
		phase_useful = 0;
		byte_mode = 1'($urandom_range(0, 1));
		alpha_a = BYTE_W'($urandom);
		alpha_b = BYTE_W'($urandom);
		load_pattern(eff);
		while (phase_useful < budget) begin
			pick = $urandom_range(0, 19);
			if (pick < 11) begin
				foreach (pattern_bytes[i])
					push_word(CMD_TEXT, pattern_bytes[i], 1'b1);
			end else if (pick < 15) begin
				repeat ($urandom_range(1, 8))
					push_word(CMD_TEXT, pick_byte(), 1'b1);
			end else if (pick < 17) begin
				idx = $urandom_range(0, eff - 1);
				flip = BYTE_W'($urandom_range(1, 255));
				foreach (pattern_bytes[i])
					push_word(CMD_TEXT,
						(i == idx) ? pattern_bytes[i] ^ flip : pattern_bytes[i], 1'b1);
			end else if (pick == 17) begin
				push_word(CMD_UNUSED, BYTE_W'($urandom), 1'b0);
				push_word(CMD_LOAD, BYTE_W'($urandom), 1'b0);
			end else begin
				push_word(CMD_RESTART, BYTE_W'($urandom), 1'b1);
				if (pick == 19)
					push_word(CMD_TEXT, BYTE_W'($urandom), 1'b0);
				load_pattern(eff);
			end
		end
	endtask

	initial begin : stim_blk
		int phase_no;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.command = CMD_LOAD;
		item_ch.byte_value = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.pattern_length = LEN_W'(1);
		set_length(LEN_W'(1));
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset length of one: early text, unused command, extra loads, restart
		push_word(CMD_TEXT, 8'hff, 1'b0);
		push_word(CMD_UNUSED, 8'h55, 1'b0);
		push_word(CMD_LOAD, 8'h00, 1'b0);
		push_word(CMD_LOAD, 8'hff, 1'b0);
		push_word(CMD_TEXT, 8'h00, 1'b0);
		push_word(CMD_TEXT, 8'hff, 1'b0);
		push_word(CMD_TEXT, 8'h00, 1'b0);
		push_word(CMD_RESTART, 8'hff, 1'b0);
		push_word(CMD_TEXT, 8'h00, 1'b0);
		push_word(CMD_LOAD, 8'hff, 1'b0);
		push_word(CMD_TEXT, 8'hff, 1'b0);

		write_length(LEN_W'(3));
		push_word(CMD_LOAD, 8'h80, 1'b0);
		push_word(CMD_LOAD, 8'h7f, 1'b0);
		push_word(CMD_LOAD, 8'h01, 1'b0);
		push_word(CMD_TEXT, 8'h80, 1'b0);
		push_word(CMD_TEXT, 8'h7f, 1'b0);
		push_word(CMD_TEXT, 8'h01, 1'b0);
		push_word(CMD_UNUSED, 8'haa, 1'b0);
		push_word(CMD_TEXT, 8'h80, 1'b0);
		push_word(CMD_TEXT, 8'h7f, 1'b0);
		push_word(CMD_TEXT, 8'h01, 1'b0);

		// zero length behaves as one
		write_length(LEN_W'(0));
		push_word(CMD_LOAD, 8'h12, 1'b0);
		push_word(CMD_TEXT, 8'h12, 1'b0);
		push_word(CMD_RESTART, 8'h00, 1'b0);

		phase_no = 0;
		while (words_pushed < WORD_TARGET) begin
			case (phase_no)
				0: begin
					no_gaps = 1'b1;
					run_phase(LEN_W'($urandom_range(2, 6)), 150);
					wait_idle();
					no_gaps = 1'b0;
				end
				// over-long length acts as the longest window
				1: run_phase(LEN_W'(511), 2 * MAX_PATTERN);
				default: begin
					if ($urandom_range(0, 19) == 0)
						run_phase(LEN_W'($urandom_range(9, 40)), $urandom_range(60, 120));
					else
						run_phase(LEN_W'($urandom_range(1, 8)), $urandom_range(40, 90));
				end
			endcase
			phase_no++;
		end

		wait_idle();
		repeat (40) @(negedge clk);
		if (predicted_matches.size() != 0)
			report_mismatch("results still pending", 0, predicted_matches.size());
		$display("covered %0d words over %0d length writes in %0d random phases",
			words_pushed, cfg_seen, phase_no);
		$display("%0d matching windows seen, %0d mismatches", windows_matched, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
